@@ sv/mtrp_pkg.sv @@
// ----------------------------------------------------------------------------
// mtrp_pkg
// Types and constants shared by the Modbus TCP request parser modules.
// ----------------------------------------------------------------------------
package mtrp_pkg;

  localparam int unsigned HDR_LEN        = 12;  // bytes kept from each frame
  localparam int unsigned MBAP_LEN       = 6;   // unit id sits right after MBAP
  localparam int unsigned WRITE_MLEN     = 6;   // length byte of a write response
  localparam int unsigned READ_MLEN_BASE = 3;   // unit id, function, byte count
  localparam int unsigned WRITE_LEN_BASE = 13;  // frame length of fc16 before data

  localparam logic [15:0] COIL_ON_WORD = 16'hFF00;

  localparam logic [7:0] FC_RD_COILS        = 8'd1;
  localparam logic [7:0] FC_READ_DISCRETE   = 8'd2;
  localparam logic [7:0] FC_READ_HOLDING    = 8'd3;
  localparam logic [7:0] FC_READ_INPUT      = 8'd4;
  localparam logic [7:0] FC_WR_COIL         = 8'd5;
  localparam logic [7:0] FC_WRITE_MULTI_REG = 8'd16;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_last;
  } in_t;

  typedef struct packed {
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [7:0]  req_function;
    logic [15:0] req_address;
    logic [15:0] req_quantity;
    logic        coil_on;
  } out_t;

  // One accepted request, as handed from the front end to the response side.
  typedef struct packed {
    logic [7:0]  txid_hi;
    logic [7:0]  txid_lo;
    logic [7:0]  mlen;
    logic [7:0]  unit;
    logic [7:0]  fc;
    logic [7:0]  byte8;     // byte count for reads, address high for writes
    logic [15:0] addr;
    logic [15:0] qty;
    logic        coil_on;
    logic        is_write;  // 12-byte response instead of 9
  } job_t;

endpackage

@@ sv/mtrp_front.sv @@
// ----------------------------------------------------------------------------
// mtrp_front
// Collects the first header bytes of a frame, counts its length and checks
// the request on the last byte; passing requests are pushed as jobs.
// ----------------------------------------------------------------------------
module mtrp_front #(
  parameter int unsigned FRAME_MAX = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  mtrp_pkg::in_t       in_data,
  input  logic                cfg_fire,
  input  logic [7:0]          cfg_data,
  output logic                job_push,
  output mtrp_pkg::job_t      job
);

  localparam int unsigned CW = $clog2(FRAME_MAX + 1);
  localparam int unsigned HL = mtrp_pkg::HDR_LEN;
  localparam int unsigned ML = mtrp_pkg::MBAP_LEN;

  logic [7:0]    hdr_r [HL];
  logic [7:0]    hdr_v [HL];
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    unit_id_r;
  logic [CW-1:0] len;
  logic [15:0]   qty;
  logic [17:0]   wlen;
  logic          qty_big, pass, fc_ok;
  logic [7:0]    bcount;

  // Current byte merged in so the checks see a frame ending at byte 11.
  always_comb begin
    for (int i = 0; i < HL; i++) begin
      hdr_v[i] = (count_r == CW'(i)) ? in_data.rx_byte : hdr_r[i];
    end
  end

  always_comb begin
    len = (count_r < CW'(FRAME_MAX)) ? count_r + CW'(1) : count_r;
    if (in_data.rx_last) begin
      count_nxt = '0;
    end else begin
      count_nxt = len;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < HL; i++) begin
        if (count_r == CW'(i)) hdr_r[i] <= in_data.rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      unit_id_r <= 8'd1;
    end else begin
      if (in_fire) count_r <= count_nxt;
      if (cfg_fire) unit_id_r <= cfg_data;
    end
  end

  assign qty     = {hdr_v[ML+4], hdr_v[ML+5]};
  assign qty_big = qty > 16'(FRAME_MAX);
  assign wlen    = 18'(mtrp_pkg::WRITE_LEN_BASE) + {1'b0, qty, 1'b0};
  assign bcount  = (qty == 16'd0) ? 8'd1 : 8'(((qty - 16'd1) >> 3) + 16'd1);

  always_comb begin
    job.txid_hi  = hdr_v[0];
    job.txid_lo  = hdr_v[1];
    job.unit     = unit_id_r;
    job.fc       = hdr_v[ML+1];
    job.addr     = {hdr_v[ML+2], hdr_v[ML+3]};
    job.qty      = qty;
    job.coil_on  = 1'b0;
    job.is_write = 1'b0;
    job.byte8    = 8'd0;
    job.mlen     = 8'd0;
    fc_ok        = 1'b0;
    case (hdr_v[ML+1])
      mtrp_pkg::FC_RD_COILS, mtrp_pkg::FC_READ_DISCRETE: begin
        fc_ok     = !qty_big && (len == CW'(HL));
        job.byte8 = bcount;
        job.mlen  = bcount + 8'(mtrp_pkg::READ_MLEN_BASE);
      end
      mtrp_pkg::FC_READ_HOLDING, mtrp_pkg::FC_READ_INPUT: begin
        fc_ok     = !qty_big && (len == CW'(HL));
        job.byte8 = {qty[6:0], 1'b0};
        job.mlen  = {qty[6:0], 1'b0} + 8'(mtrp_pkg::READ_MLEN_BASE);
      end
      mtrp_pkg::FC_WR_COIL: begin
        fc_ok        = (len == CW'(HL));
        job.coil_on  = (qty == mtrp_pkg::COIL_ON_WORD);
        job.is_write = 1'b1;
        job.byte8    = hdr_v[ML+2];
        job.mlen     = 8'(mtrp_pkg::WRITE_MLEN);
      end
      mtrp_pkg::FC_WRITE_MULTI_REG: begin
        fc_ok        = !qty_big && (18'(len) == wlen);
        job.is_write = 1'b1;
        job.byte8    = hdr_v[ML+2];
        job.mlen     = 8'(mtrp_pkg::WRITE_MLEN);
      end
      default: fc_ok = 1'b0;
    endcase
  end

  assign pass     = (len >= CW'(HL)) && (hdr_v[ML] == unit_id_r) && fc_ok;
  assign job_push = in_fire && in_data.rx_last && pass;

endmodule

@@ sv/mtrp_queue.sv @@
// ----------------------------------------------------------------------------
// mtrp_queue
// Small job FIFO between request checking and response generation.
// ----------------------------------------------------------------------------
module mtrp_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mtrp_pkg::job_t  push_job,
  input  logic            pop,
  output mtrp_pkg::job_t  head,
  output logic            empty,
  output logic            full
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  mtrp_pkg::job_t mem_r [DEPTH];
  logic [PW-1:0]  wr_r, rd_r;
  logic [NW-1:0]  cnt_r;

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == NW'(DEPTH));
  assign head  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= adv(wr_r);
      if (pop) rd_r <= adv(rd_r);
      if (push && !pop) cnt_r <= cnt_r + NW'(1);
      else if (pop && !push) cnt_r <= cnt_r - NW'(1);
    end
  end

endmodule

@@ sv/mtrp_back.sv @@
// ----------------------------------------------------------------------------
// mtrp_back
// Walks the head job byte by byte into a registered output stage.
// ----------------------------------------------------------------------------
module mtrp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  mtrp_pkg::job_t  head,
  input  logic            empty,
  output logic            pop,
  input  logic            out_stall,
  output logic            out_valid,
  output mtrp_pkg::out_t  out_data
);

  logic [3:0]     idx_r;
  logic           valid_r;
  mtrp_pkg::out_t out_r, out_nxt;
  logic           load, last;

  assign load = !empty && (!valid_r || !out_stall);
  assign last = head.is_write ? (idx_r == 4'(mtrp_pkg::HDR_LEN - 1)) : (idx_r == 4'd8);
  assign pop  = load && last;

  always_comb begin
    out_nxt.tx_last      = last;
    out_nxt.req_function = head.fc;
    out_nxt.req_address  = head.addr;
    out_nxt.req_quantity = head.qty;
    out_nxt.coil_on      = head.coil_on;
    case (idx_r)
      4'd0:    out_nxt.tx_byte = head.txid_hi;
      4'd1:    out_nxt.tx_byte = head.txid_lo;
      4'd5:    out_nxt.tx_byte = head.mlen;
      4'd6:    out_nxt.tx_byte = head.unit;
      4'd7:    out_nxt.tx_byte = head.fc;
      4'd8:    out_nxt.tx_byte = head.byte8;
      4'd9:    out_nxt.tx_byte = head.addr[7:0];
      4'd10:   out_nxt.tx_byte = head.qty[15:8];
      4'd11:   out_nxt.tx_byte = head.qty[7:0];
      default: out_nxt.tx_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= last ? 4'd0 : idx_r + 4'd1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = valid_r;
  assign out_data  = out_r;

endmodule

@@ sv/modbus_tcp_request_parser.sv @@
// ----------------------------------------------------------------------------
// modbus_tcp_request_parser
// Modbus TCP slave request parser: checks a received frame and emits the
// response header together with the decoded request.
//
// Feed one frame byte per transaction with rx_last on the final byte; bytes
// are taken every cycle while the job queue has room. On the final byte the
// frame is checked (length of at least 12, unit id equal to the configured
// value, function code 1, 2, 3, 4, 5 or 16, and the length and quantity
// rules of that code) in the same cycle, and a passing request is queued.
// The response side then streams 9 header bytes for reads (ending with the
// data byte count) or 12 for writes (ending with the echoed address and
// quantity or value), each carrying the decoded request. Failing frames
// produce nothing. The first response byte passes through the job queue
// and the output register after the final frame byte is taken; output
// throughput is one byte per cycle while out_stall is low, with no gap
// between bursts, and input stalls only when QUEUE_DEPTH requests are
// queued or being sent. The unit id register (reset 1) is to be written over
// cfg_valid/cfg_data by the user only while idle; the block does not check.
// ----------------------------------------------------------------------------
module modbus_tcp_request_parser #(
  parameter int unsigned FRAME_MAX   = 64,  // 12 .. 256
  parameter int unsigned QUEUE_DEPTH = 2    // at least 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  mtrp_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output mtrp_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [7:0]     cfg_data
);

  logic           in_fire, cfg_fire;
  logic           q_push, q_pop, q_empty, q_full;
  mtrp_pkg::job_t push_job, head_job;

  // Hold input only when the queue cannot take another request.
  assign in_stall  = q_full;
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  mtrp_front #(.FRAME_MAX(FRAME_MAX)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_data  (in_data),
    .cfg_fire (cfg_fire),
    .cfg_data (cfg_data),
    .job_push (q_push),
    .job      (push_job)
  );

  mtrp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head     (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  mtrp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head_job),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Never push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full)) else $error("job queue overflow");

  // A response burst runs without gaps once started.
  a_burst_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.tx_last |=> out_valid)
    else $error("gap inside response burst");

  // The last byte of a multiple register write echoes the quantity low byte.
  a_fc16_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.tx_last &&
    out_data.req_function == mtrp_pkg::FC_WRITE_MULTI_REG |->
    out_data.tx_byte == out_data.req_quantity[7:0])
    else $error("bad final byte for multiple register write");

  // Coil flag only for single coil writes.
  a_coil_fc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.coil_on |-> out_data.req_function == mtrp_pkg::FC_WR_COIL)
    else $error("coil_on with wrong function code");

endmodule
